// ----- design/mahs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions of the MPEG audio header scanner.
// No dependencies; used by the front end, queue, back end and top level.
package mahs_pkg;

  // Position counter width default
  localparam int POSITION_BITS_DEF = 32;

  // Header queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Frame length arithmetic
  localparam int FRAME_FACTOR = 144000;
  localparam int KBPS_BITS    = 9;
  localparam int RATE_BITS    = 16;
  localparam int PROD_BITS    = 27;
  localparam int QUOT_BITS    = 13;

  // Output beat packing
  localparam int OUT_DATA_BITS = 80;

  // Sync and reserved codes
  localparam logic [7:0] SYNC_BYTE      = 8'hff;
  localparam logic [2:0] SYNC_TOP       = 3'b111;
  localparam logic [1:0] VER_RESERVED   = 2'b01;
  localparam logic [1:0] VER_CODE_MPEG1 = 2'b11;
  localparam logic [1:0] VER_CODE_MPEG2 = 2'b10;
  localparam logic [1:0] LAYER_RESERVED = 2'b00;
  localparam logic [3:0] BR_RESERVED    = 4'b1111;
  localparam logic [1:0] SR_RESERVED    = 2'b11;
  localparam logic [1:0] EMPH_RESERVED  = 2'b10;

  // Decoded version numbers
  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  // Decoded layer numbers
  localparam logic [1:0] LAYER_1 = 2'd1;
  localparam logic [1:0] LAYER_2 = 2'd2;

  // Bitrate tables in kbit/s
  localparam logic [8:0] RATE_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] RATE_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] RATE_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] RATE_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] RATE_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // Base sample rates, before the per-version divide
  localparam logic [15:0] BASE_RATE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

  // Decoded header as it travels through the queue
  typedef struct packed {
    logic [31:0]          offset;
    logic [1:0]           version;
    logic [1:0]           layer;
    logic                 crc;
    logic [KBPS_BITS-1:0] kbps;
    logic [RATE_BITS-1:0] rate;
    logic                 pad;
    logic [1:0]           chmode;
  } mahs_hdr_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } mahs_back_state_e;

  // Bitrate lookup by decoded version, layer and index
  function automatic logic [8:0] kbps_lookup(logic [1:0] version, logic [1:0] layer,
                                              logic [3:0] idx);
    logic [8:0] kbps;
    if (version == VER_MPEG1) begin
      if (layer == LAYER_1) begin
        kbps = RATE_V1_L1[idx];
      end else if (layer == LAYER_2) begin
        kbps = RATE_V1_L2[idx];
      end else begin
        kbps = RATE_V1_L3[idx];
      end
    end else begin
      if (layer == LAYER_1) begin
        kbps = RATE_V2_L1[idx];
      end else begin
        kbps = RATE_V2_L23[idx];
      end
    end
    return kbps;
  endfunction

  // Sample rate: base rate halved once per version step
  function automatic logic [15:0] rate_lookup(logic [1:0] version, logic [1:0] sr_idx);
    logic [15:0] rate;
    rate = BASE_RATE[sr_idx] >> version;
    return rate;
  endfunction

endpackage

// ----- design/mahs_front.sv -----
`timescale 1ns / 1ps
// Front end: byte window, position counter and header test/classification.
// Depends on mahs_pkg; pushes decoded headers into mahs_fifo.
module mahs_front #(
  parameter int POSITION_BITS = mahs_pkg::POSITION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                push_o,
  output mahs_pkg::mahs_hdr_t hdr_o
);

  logic [7:0]               win_q [3];
  logic [7:0]               win_d [3];
  logic [1:0]               fill_q, fill_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;

  logic [POSITION_BITS-1:0] offset;
  logic [POSITION_BITS+31:0] offset_ext;
  logic [1:0] ver_code, layer_code, sr_idx, emph, version, layer;
  logic [3:0] br_idx;
  logic       hdr_ok;

  // Pick header fields out of the window and the new byte
  assign ver_code   = win_q[1][4:3];
  assign layer_code = win_q[1][2:1];
  assign br_idx     = win_q[2][7:4];
  assign sr_idx     = win_q[2][3:2];
  assign emph       = byte_i[1:0];

  always_comb begin
    hdr_ok = (fill_q == 2'd3) && (win_q[0] == mahs_pkg::SYNC_BYTE) &&
             (win_q[1][7:5] == mahs_pkg::SYNC_TOP) &&
             (ver_code != mahs_pkg::VER_RESERVED) &&
             (layer_code != mahs_pkg::LAYER_RESERVED) &&
             (br_idx != mahs_pkg::BR_RESERVED) &&
             (sr_idx != mahs_pkg::SR_RESERVED) &&
             (emph != mahs_pkg::EMPH_RESERVED);
    if (ver_code == mahs_pkg::VER_CODE_MPEG1) begin
      version = mahs_pkg::VER_MPEG1;
    end else if (ver_code == mahs_pkg::VER_CODE_MPEG2) begin
      version = mahs_pkg::VER_MPEG2;
    end else begin
      version = mahs_pkg::VER_MPEG25;
    end
    layer = 2'(3'd4 - {1'b0, layer_code});
  end

  // Offset of the header's first byte, wrapped, then cut to 32 bits
  assign offset     = pos_q - POSITION_BITS'(3);
  assign offset_ext = {32'd0, offset};

  // Build the queue record
  always_comb begin
    hdr_o.offset  = offset_ext[31:0];
    hdr_o.version = version;
    hdr_o.layer   = layer;
    hdr_o.crc     = ~win_q[1][0];
    hdr_o.kbps    = mahs_pkg::kbps_lookup(version, layer, br_idx);
    hdr_o.rate    = mahs_pkg::rate_lookup(version, sr_idx);
    hdr_o.pad     = win_q[2][1];
    hdr_o.chmode  = byte_i[7:6];
  end

  assign push_o = beat_i && hdr_ok;

  // Shift the window and advance the position; clear after the last byte
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    pos_d  = pos_q;
    if (beat_i) begin
      if (last_i) begin
        win_d  = '{8'd0, 8'd0, 8'd0};
        fill_d = 2'd0;
        pos_d  = '0;
      end else begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = byte_i;
        if (fill_q != 2'd3) begin
          fill_d = fill_q + 2'd1;
        end
        pos_d = pos_q + POSITION_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '{8'd0, 8'd0, 8'd0};
      fill_q <= 2'd0;
      pos_q  <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      pos_q  <= pos_d;
    end
  end

endmodule

// ----- design/mahs_fifo.sv -----
`timescale 1ns / 1ps
// Short header queue that decouples the front end from the back end.
// Depends on mahs_pkg for the record type and depth.
module mahs_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mahs_pkg::mahs_hdr_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output mahs_pkg::mahs_hdr_t pop_data_o
);

  localparam int Depth   = mahs_pkg::QUEUE_DEPTH;
  localparam int PtrBits = $clog2(Depth);
  localparam int CntBits = $clog2(Depth + 1);

  mahs_pkg::mahs_hdr_t mem_q [Depth];
  logic [PtrBits-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == CntBits'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + PtrBits'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- design/mahs_back.sv -----
`timescale 1ns / 1ps
// Back end: frame length by multiply and bit-serial restoring divide, output register.
// Depends on mahs_pkg; pops records from mahs_fifo.
module mahs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mahs_pkg::mahs_hdr_t hdr_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [mahs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int ProdBits = mahs_pkg::PROD_BITS;
  localparam int QuotBits = mahs_pkg::QUOT_BITS;
  localparam int DivBits  = mahs_pkg::RATE_BITS + QuotBits - 1;
  localparam int StepBits = $clog2(QuotBits);
  localparam int PadBits  = mahs_pkg::OUT_DATA_BITS - 78;

  mahs_pkg::mahs_back_state_e state_q, state_d;
  mahs_pkg::mahs_hdr_t        hdr_q, hdr_d;
  logic [ProdBits-1:0]        rem_q, rem_d;
  logic [DivBits-1:0]         dsh_q, dsh_d;
  logic [QuotBits-1:0]        quot_q, quot_d;
  logic [StepBits-1:0]        step_q, step_d;
  logic [DivBits-1:0]         rem_ext;
  logic [DivBits:0]           diff;
  logic [QuotBits-1:0]        frame_len;

  // One restoring step: trial subtract of the shifted divisor
  assign rem_ext = DivBits'(rem_q);
  assign diff    = {1'b0, rem_ext} - {1'b0, dsh_q};

  always_comb begin
    state_d = state_q;
    hdr_d   = hdr_q;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quot_d  = quot_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    unique case (state_q)
      mahs_pkg::BK_IDLE: begin
        if (valid_i) begin
          pop_o   = 1'b1;
          hdr_d   = hdr_i;
          state_d = mahs_pkg::BK_MUL;
        end
      end
      mahs_pkg::BK_MUL: begin
        rem_d   = ProdBits'(mahs_pkg::FRAME_FACTOR) * ProdBits'(hdr_q.kbps);
        dsh_d   = {hdr_q.rate, (QuotBits - 1)'(0)};
        quot_d  = '0;
        step_d  = '0;
        state_d = mahs_pkg::BK_DIV;
      end
      mahs_pkg::BK_DIV: begin
        if (!diff[DivBits]) begin
          rem_d  = ProdBits'(diff[DivBits-1:0]);
          quot_d = {quot_q[QuotBits-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[QuotBits-2:0], 1'b0};
        end
        dsh_d  = dsh_q >> 1;
        step_d = step_q + StepBits'(1);
        if (step_q == StepBits'(QuotBits - 1)) begin
          state_d = mahs_pkg::BK_OUT;
        end
      end
      mahs_pkg::BK_OUT: begin
        if (m_axis_tready) begin
          state_d = mahs_pkg::BK_IDLE;
        end
      end
      default: state_d = mahs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mahs_pkg::BK_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  // Pack the result beat
  assign frame_len     = quot_q + QuotBits'(hdr_q.pad);
  assign m_axis_tvalid = (state_q == mahs_pkg::BK_OUT);
  assign m_axis_tdata  = {PadBits'(0), frame_len, hdr_q.chmode, hdr_q.pad, hdr_q.rate,
                          hdr_q.kbps, hdr_q.crc, hdr_q.layer, hdr_q.version, hdr_q.offset};

endmodule

// ----- design/mpeg_audio_header_scanner_core.sv -----
`timescale 1ns / 1ps
// Input: one byte per cycle while the four-entry header queue has room.
// Each valid header takes the back end through pop, multiply, 13 divide steps and
// output, plus any wait on m_axis_tready; a result follows the beat that completes
// its header via the queue and the pop, multiply, divide and output states when the
// back end is free. The divide loop sets the header rate; bytes keep flowing while it runs and the queue has room.
// Reset clears window, fill count, position, queue and sequencer at once.
module mpeg_audio_header_scanner_core #(
  parameter int POSITION_BITS = mahs_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] header_offset, [33:32] audio_version, [35:34] layer_number,
  // [36] crc_present, [45:37] bitrate_kbps, [61:46] sample_rate_hz,
  // [62] padding_flag, [64:63] channel_mode, [77:65] frame_length_bytes,
  // [79:78] zero
  output logic [79:0] m_axis_tdata
);

  logic                full, push, pop, q_valid, beat;
  mahs_pkg::mahs_hdr_t push_hdr, pop_hdr;

  assign s_axis_tready = !full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  mahs_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (s_axis_tdata),
    .last_i (s_axis_tlast),
    .push_o (push),
    .hdr_o  (push_hdr)
  );

  mahs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_hdr),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_hdr)
  );

  mahs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .hdr_i         (pop_hdr),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- design/mahs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the MPEG audio header scanner, bound to the top level.
// Depends only on the top level's ports.
module mahs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Free format gives a frame length equal to the padding bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[45:37] == 9'd0) |->
      (m_axis_tdata[77:65] == {12'd0, m_axis_tdata[62]}))
    else $error("free-format frame length wrong");

  // Sample rate never below the lowest MPEG-2.5 rate, layer never zero, bits [79:78] zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[61:46] >= 16'd8000) && (m_axis_tdata[35:34] != 2'd0)
      && (m_axis_tdata[79:78] == 2'd0))
    else $error("result fields out of range");

endmodule

bind mpeg_audio_header_scanner_core mahs_checker u_mahs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
